[rtl/lpd_pkg.sv]
// Package for the length-prefixed deframer: result beat type, phase codes,
// register map and reset constants. No dependencies.
package lpd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = FifoPtrW + 1;

  localparam logic [ByteW-1:0] MaxLenReset = 8'd255;
  localparam logic [ByteW-1:0] MinLen      = 8'd2;

  // register index taken from paddr[2]
  localparam logic RegMaxPacketLength = 1'b0;

  typedef enum logic [1:0] {
    PhHdrLow,
    PhHdrHigh,
    PhBody
  } lpd_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] byte_position;
    logic             packet_end;
    logic             length_error;
  } lpd_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    lpd_result_t res0;
    lpd_result_t res1;
  } lpd_push_t;

endpackage

[rtl/lpd_fifo.sv]
// Four-entry result queue taking up to two beats per cycle and giving one per cycle while ready_i is high.
// Depends on lpd_pkg.
module lpd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpd_pkg::lpd_push_t push_i,
  output logic               space2_o,
  output logic               valid_o,
  input  logic               ready_i,
  output lpd_pkg::lpd_result_t data_o
);
  import lpd_pkg::*;

  lpd_result_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign valid_o  = (cnt_q != '0);
  assign data_o   = mem_q[rptr_q];
  assign pop      = valid_o && ready_i;
  assign space2_o = (cnt_q <= FifoCntW'(FifoDepth - 2));

  always_comb begin
    wptr_d = wptr_q + FifoPtrW'(push_i.cnt);
    rptr_d = rptr_q + FifoPtrW'(pop);
    cnt_d  = cnt_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_q + FifoPtrW'(1)] <= push_i.res1;
    end
  end

endmodule

[rtl/length_prefixed_deframer_top.sv]
// Length-prefixed deframer top level: header parse, cut-through byte pass,
// APB limit register. Depends on lpd_pkg and lpd_fifo.
// Result beats are registered in the result queue before they reach the outputs.
// Throughput: one input byte per cycle while the queue has room for two beats;
// a valid second header byte yields two beats, absorbed by the four-entry result queue.
// Reset: asynchronous active low; framing waits for a header, limit is 255.
module length_prefixed_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpd_pkg::PaddrW-1:0]  paddr,
  input  logic [lpd_pkg::PdataW-1:0]  pwdata,
  output logic [lpd_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lpd_pkg::ByteW-1:0]   data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lpd_pkg::ByteW-1:0]   out_byte_o,
  output logic [lpd_pkg::ByteW-1:0]   byte_position_o,
  output logic                        packet_end_o,
  output logic                        length_error_o
);
  import lpd_pkg::*;

  lpd_phase_e        phase_q, phase_d;
  logic [ByteW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  hdr_low_q, hdr_low_d;
  logic [ByteW-1:0]  cur_len_q, cur_len_d;
  logic [ByteW-1:0]  max_len_q;
  logic              accept;
  logic              len_bad;
  logic              body_last;
  logic [ByteW:0]    pos_inc;
  logic              fifo_space2;
  lpd_push_t         push;
  lpd_result_t       out_res;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxPacketLength) ? PdataW'(max_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == RegMaxPacketLength) begin
      max_len_q <= pwdata[ByteW-1:0];
    end
  end

  assign in_ready_o = fifo_space2;
  assign accept     = in_valid_i && in_ready_o;

  assign len_bad   = (data_byte_i != '0) || (hdr_low_q < MinLen) || (hdr_low_q > max_len_q);
  assign pos_inc   = {1'b0, count_q} + (ByteW+1)'(1);
  assign body_last = (pos_inc >= {1'b0, cur_len_q});

  // next state
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    hdr_low_d = hdr_low_q;
    cur_len_d = cur_len_q;
    if (accept) begin
      unique case (phase_q)
        PhHdrLow: begin
          hdr_low_d = data_byte_i;
          phase_d   = PhHdrHigh;
        end
        PhHdrHigh: begin
          if (len_bad) begin
            phase_d = PhHdrLow;
          end else begin
            cur_len_d = hdr_low_q;
            count_d   = 8'd2;
            phase_d   = (hdr_low_q == MinLen) ? PhHdrLow : PhBody;
          end
        end
        PhBody: begin
          count_d = pos_inc[ByteW-1:0];
          if (body_last) begin
            phase_d = PhHdrLow;
          end
        end
        default: phase_d = PhHdrLow;
      endcase
    end
  end

  // result beats
  always_comb begin
    push     = '0;
    if (accept) begin
      unique case (phase_q)
        PhHdrLow: push.cnt = 2'd0;
        PhHdrHigh: begin
          if (len_bad) begin
            push.cnt               = 2'd1;
            push.res0.length_error = 1'b1;
          end else begin
            push.cnt                 = 2'd2;
            push.res0.out_byte       = hdr_low_q;
            push.res1.out_byte       = data_byte_i;
            push.res1.byte_position  = 8'd1;
            push.res1.packet_end     = (hdr_low_q == MinLen);
          end
        end
        PhBody: begin
          push.cnt                = 2'd1;
          push.res0.out_byte      = data_byte_i;
          push.res0.byte_position = count_q;
          push.res0.packet_end    = body_last;
        end
        default: push.cnt = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdrLow;
      count_q   <= '0;
      hdr_low_q <= '0;
      cur_len_q <= '0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      hdr_low_q <= hdr_low_d;
      cur_len_q <= cur_len_d;
    end
  end

  lpd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space2_o (fifo_space2),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_res)
  );

  assign out_byte_o      = out_res.out_byte;
  assign byte_position_o = out_res.byte_position;
  assign packet_end_o    = out_res.packet_end;
  assign length_error_o  = out_res.length_error;

endmodule

[rtl/lpd_checker.sv]
// Port-level checks for the length-prefixed deframer, bound to the top level.
// Depends on length_prefixed_deframer_top ports only.
module lpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [7:0] byte_position_o,
  input logic       packet_end_o,
  input logic       length_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_position_o) && $stable(packet_end_o) && $stable(length_error_o))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> out_byte_o == 8'd0 && byte_position_o == 8'd0
      && !packet_end_o)
    else $error("error beat carries payload");

  a_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_end_o |-> byte_position_o != 8'd0 && byte_position_o != 8'd255)
    else $error("packet end at impossible position");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind length_prefixed_deframer_top lpd_checker u_lpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_byte_o      (out_byte_o),
  .byte_position_o (byte_position_o),
  .packet_end_o    (packet_end_o),
  .length_error_o  (length_error_o)
);
